[hdl/rlil_pkg.sv]
package rlil_pkg;

    localparam int unsigned TargetWidth = 30;
    localparam int unsigned RunWidth    = 31;
    localparam int unsigned RemWidth    = 33;
    localparam int unsigned ValueWidth  = 8;
    localparam int unsigned CfgIdxWidth = 3;

    localparam logic [RunWidth-1:0] RunMax = {RunWidth{1'b1}};

    typedef logic [1:0] t_sym;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_DATA  = 1'b1
    } t_req;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_VALUE_SYM0 = 3'd0,
        CFG_VALUE_SYM1 = 3'd1,
        CFG_VALUE_SYM2 = 3'd2,
        CFG_VALUE_SYM3 = 3'd3,
        CFG_START_MAP0 = 3'd4,
        CFG_START_MAP1 = 3'd5,
        CFG_START_MAP2 = 3'd6,
        CFG_START_MAP3 = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic                   req_type;
        logic [TargetWidth-1:0] target_index;
        logic [1:0]             start_code;
        logic [7:0]             data_byte;
        logic                   block_end;
    } t_in_item;

    typedef struct packed {
        logic [ValueWidth-1:0] entry_value;
        logic                  from_block_end;
    } t_out_item;

    // next symbol after a run, picked by the current symbol and head bit 6
    function automatic t_sym succ_sym(input t_sym cur, input logic rank);
        t_sym res;
        case (cur)
            2'd0: res = 2'd0;
            2'd1: res = rank ? 2'd3 : 2'd2;
            2'd2: res = rank ? 2'd3 : 2'd1;
            2'd3: res = rank ? 2'd2 : 2'd1;
            default: res = 2'd0;
        endcase
        return res;
    endfunction

endpackage

[hdl/run_length_index_lookup.sv]
// Run-length lookup of one entry in a coded block. A start transfer loads the
// sought offset and the initial symbol; each following data transfer carries
// one coded byte (head byte: run length in bits 4..0, successor select in
// bit 6, single exception entry in bit 5, extension follows in bit 7;
// extension bytes add 7 bits each). Once the offset is passed, or the block
// ends, one result with the symbol's configured value comes out and the
// lookup goes idle until the next start. The whole byte update (one saturating
// add, one subtract against the remaining offset) settles between the state
// registers, and a result sits in an output register, so a new item is taken
// each cycle unless a held result is stalled. A byte's result appears in the
// output register in the cycle after the byte is taken.
module run_length_index_lookup (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rlil_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rlil_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rlil_pkg::CfgIdxWidth-1:0]    i_cfg_index,
    input  logic [rlil_pkg::ValueWidth-1:0]     i_cfg_wdata
);
    import rlil_pkg::*;

    logic [ValueWidth-1:0] r_value_sym [4];
    t_sym                  r_start_map [4];

    logic [RemWidth-1:0]   r_rem, n_rem;
    t_sym                  r_sym, n_sym;
    logic [RunWidth-1:0]   r_run, n_run;
    logic [2:0]            r_cnt, n_cnt;
    logic                  r_in_ext, n_in_ext;
    logic                  r_active, n_active;

    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  in_acc;
    logic                  emit;
    logic                  emit_flag;
    t_sym                  emit_sym;
    logic [7:0]            byte_in;
    t_sym                  succ;
    logic [RemWidth-1:0]   rem_b;
    logic [2:0]            cnt_inc;
    logic [RunWidth+2:0]   ext_term;
    logic [RunWidth+2:0]   run_sum;
    logic [RunWidth-1:0]   run_sat;
    logic                  done;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign byte_in = i_in_data.data_byte;
    assign succ    = succ_sym(r_sym, byte_in[6]);
    assign rem_b   = byte_in[5] ? r_rem - RemWidth'(1) : r_rem;
    assign cnt_inc = (r_cnt == 3'd7) ? 3'd7 : r_cnt + 3'd1;

    // extension byte k lands at bit 7k-2; from the fifth on, any nonzero
    // payload is past the saturation limit
    always_comb begin
        case (cnt_inc)
            3'd1: ext_term = (RunWidth+3)'(byte_in[6:0]) << 5;
            3'd2: ext_term = (RunWidth+3)'(byte_in[6:0]) << 12;
            3'd3: ext_term = (RunWidth+3)'(byte_in[6:0]) << 19;
            3'd4: ext_term = (RunWidth+3)'(byte_in[6:0]) << 26;
            default: ext_term = (byte_in[6:0] != 7'd0) ?
                                (RunWidth+3)'(RunMax) + (RunWidth+3)'(1) :
                                '0;
        endcase
    end

    assign run_sum = (RunWidth+3)'(r_run) + ext_term;
    assign run_sat = (run_sum > (RunWidth+3)'(RunMax)) ? RunMax : run_sum[RunWidth-1:0];

    always_comb begin
        n_rem     = r_rem;
        n_sym     = r_sym;
        n_run     = r_run;
        n_cnt     = r_cnt;
        n_in_ext  = r_in_ext;
        n_active  = r_active;
        emit      = 1'b0;
        emit_flag = 1'b0;
        emit_sym  = r_sym;
        done      = 1'b0;
        if (in_acc) begin
            if (i_in_data.req_type == REQ_START) begin
                n_rem    = RemWidth'(i_in_data.target_index);
                n_sym    = r_start_map[i_in_data.start_code];
                n_run    = '0;
                n_cnt    = '0;
                n_in_ext = 1'b0;
                n_active = 1'b1;
            end else if (r_active) begin
                if (!r_in_ext) begin
                    if (byte_in[5] && r_rem == '0) begin
                        // exception entry is the one sought
                        emit     = 1'b1;
                        emit_sym = succ;
                        done     = 1'b1;
                    end else begin
                        n_sym    = byte_in[5] ? r_sym : succ;
                        n_run    = RunWidth'(byte_in[4:0]);
                        n_cnt    = '0;
                        n_in_ext = byte_in[7];
                        n_rem    = byte_in[7] ? rem_b : rem_b - RemWidth'(byte_in[4:0]);
                    end
                end else begin
                    n_cnt = cnt_inc;
                    n_run = run_sat;
                    if (!byte_in[7]) begin
                        n_in_ext = 1'b0;
                        n_rem    = r_rem - RemWidth'(run_sat);
                    end
                end
                if (!done) begin
                    emit_sym = n_sym;
                    if (!n_in_ext && n_rem[RemWidth-1]) begin
                        emit = 1'b1;
                    end else if (i_in_data.block_end) begin
                        emit      = 1'b1;
                        emit_flag = 1'b1;
                    end
                end
                if (emit) begin
                    n_active = 1'b0;
                    n_in_ext = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem          <= '0;
            r_sym          <= '0;
            r_run          <= '0;
            r_cnt          <= '0;
            r_in_ext       <= 1'b0;
            r_active       <= 1'b0;
            r_out_valid    <= 1'b0;
            r_value_sym[0] <= '0;
            r_value_sym[1] <= '0;
            r_value_sym[2] <= '0;
            r_value_sym[3] <= '0;
            r_start_map[0] <= 2'd0;
            r_start_map[1] <= 2'd1;
            r_start_map[2] <= 2'd2;
            r_start_map[3] <= 2'd3;
        end else begin
            r_rem    <= n_rem;
            r_sym    <= n_sym;
            r_run    <= n_run;
            r_cnt    <= n_cnt;
            r_in_ext <= n_in_ext;
            r_active <= n_active;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_VALUE_SYM0: r_value_sym[0] <= i_cfg_wdata;
                    CFG_VALUE_SYM1: r_value_sym[1] <= i_cfg_wdata;
                    CFG_VALUE_SYM2: r_value_sym[2] <= i_cfg_wdata;
                    CFG_VALUE_SYM3: r_value_sym[3] <= i_cfg_wdata;
                    CFG_START_MAP0: r_start_map[0] <= i_cfg_wdata[1:0];
                    CFG_START_MAP1: r_start_map[1] <= i_cfg_wdata[1:0];
                    CFG_START_MAP2: r_start_map[2] <= i_cfg_wdata[1:0];
                    CFG_START_MAP3: r_start_map[3] <= i_cfg_wdata[1:0];
                    default: ;
                endcase
            end
        end
    end

    // load the result slot only with a fresh result
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.entry_value    <= r_value_sym[emit_sym];
            r_out.from_block_end <= emit_flag;
        end
    end

`ifndef SYNTHESIS
    a_ext_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ext |-> r_active)
        else $error("extension pending without an open lookup");

    a_rem_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> !r_rem[RemWidth-1])
        else $error("open lookup with negative remaining offset");

    a_start_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.req_type == REQ_START && !i_out_stall) |=> !o_out_valid)
        else $error("start transfer produced a result");

    a_start_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.req_type == REQ_START) |=> (r_active && !r_in_ext))
        else $error("start transfer did not open a lookup");
`endif

endmodule
